>>> rtl/core/sls_pkg.sv
// Types, codes and character classes for the script lexer.
// Depends on nothing; used by script_lexer_stream.
package sls_pkg;

    localparam logic [4:0] M_IDLE  = 5'd0;
    localparam logic [4:0] M_IDENT = 5'd1;
    localparam logic [4:0] M_VAR   = 5'd2;
    localparam logic [4:0] M_MAP   = 5'd3;
    localparam logic [4:0] M_INT   = 5'd4;
    localparam logic [4:0] M_STR   = 5'd5;
    localparam logic [4:0] M_ESC   = 5'd6;
    localparam logic [4:0] M_HEX   = 5'd7;
    localparam logic [4:0] M_OCT   = 5'd8;
    localparam logic [4:0] M_OP    = 5'd9;
    localparam logic [4:0] M_LINE  = 5'd10;
    localparam logic [4:0] M_BLOCK = 5'd11;
    localparam logic [4:0] M_STAR  = 5'd12;

    localparam logic [4:0] T_INT     = 5'd0;
    localparam logic [4:0] T_STR     = 5'd1;
    localparam logic [4:0] T_IDENT   = 5'd2;
    localparam logic [4:0] T_VAR     = 5'd3;
    localparam logic [4:0] T_MAP     = 5'd4;
    localparam logic [4:0] T_COMMA   = 5'd5;
    localparam logic [4:0] T_OP      = 5'd6;
    localparam logic [4:0] T_QUEST   = 5'd7;
    localparam logic [4:0] T_COLON   = 5'd8;
    localparam logic [4:0] T_SEMI    = 5'd9;
    localparam logic [4:0] T_LBRACE  = 5'd10;
    localparam logic [4:0] T_RBRACE  = 5'd11;
    localparam logic [4:0] T_LBRACK  = 5'd12;
    localparam logic [4:0] T_RBRACK  = 5'd13;
    localparam logic [4:0] T_LPAREN  = 5'd14;
    localparam logic [4:0] T_RPAREN  = 5'd15;
    localparam logic [4:0] T_END     = 5'd16;
    localparam logic [4:0] T_UNKNOWN = 5'd17;

    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_ASSIGN = 5'd1;
    localparam logic [4:0] OP_EQ     = 5'd2;
    localparam logic [4:0] OP_NE     = 5'd3;
    localparam logic [4:0] OP_LE     = 5'd4;
    localparam logic [4:0] OP_GE     = 5'd5;
    localparam logic [4:0] OP_SHL    = 5'd6;
    localparam logic [4:0] OP_SHR    = 5'd7;
    localparam logic [4:0] OP_LT     = 5'd8;
    localparam logic [4:0] OP_GT     = 5'd9;
    localparam logic [4:0] OP_LAND   = 5'd10;
    localparam logic [4:0] OP_LOR    = 5'd11;
    localparam logic [4:0] OP_PLUS   = 5'd12;
    localparam logic [4:0] OP_INC    = 5'd13;
    localparam logic [4:0] OP_DEC    = 5'd14;
    localparam logic [4:0] OP_MINUS  = 5'd15;
    localparam logic [4:0] OP_MUL    = 5'd16;
    localparam logic [4:0] OP_DIV    = 5'd17;
    localparam logic [4:0] OP_MOD    = 5'd18;
    localparam logic [4:0] OP_BAND   = 5'd19;
    localparam logic [4:0] OP_BOR    = 5'd20;
    localparam logic [4:0] OP_XOR    = 5'd21;
    localparam logic [4:0] OP_NOT    = 5'd22;
    localparam logic [4:0] OP_BNOT   = 5'd23;

    typedef struct packed {
        logic        kind;
        logic [4:0]  ttype;
        logic [4:0]  op;
        logic [7:0]  byte_val;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [4:0] mode;
        logic       mark;
        logic       emit;
        logic       kind;
        logic [4:0] ttype;
        logic [4:0] op;
        logic [7:0] byte_val;
    } t_start;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic [4:0] mode_type(input logic [4:0] m);
        logic [4:0] t;
        case (m)
            M_VAR:   t = T_VAR;
            M_MAP:   t = T_MAP;
            M_INT:   t = T_INT;
            default: t = T_IDENT;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] single_op(input logic [7:0] p);
        logic [4:0] o;
        case (p)
            "=":     o = OP_ASSIGN;
            "!":     o = OP_NOT;
            "+":     o = OP_PLUS;
            "-":     o = OP_MINUS;
            "&":     o = OP_BAND;
            "|":     o = OP_BOR;
            "<":     o = OP_LT;
            ">":     o = OP_GT;
            default: o = OP_DIV;
        endcase
        return o;
    endfunction

    function automatic logic [4:0] punct_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            ",":     t = T_COMMA;
            "?":     t = T_QUEST;
            ":":     t = T_COLON;
            ";":     t = T_SEMI;
            "{":     t = T_LBRACE;
            "}":     t = T_RBRACE;
            "[":     t = T_LBRACK;
            "]":     t = T_RBRACK;
            "(":     t = T_LPAREN;
            ")":     t = T_RPAREN;
            default: t = T_INT;
        endcase
        return t;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        r = 5'd0;
        if (c inside {["0":"9"]}) begin
            d = c - "0";
            r = {1'b1, d[3:0]};
        end else if (c inside {["a":"f"]}) begin
            d = c - "a" + 8'd10;
            r = {1'b1, d[3:0]};
        end else if (c inside {["A":"F"]}) begin
            d = c - "A" + 8'd10;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic t_start start_token(input logic [7:0] c);
        t_start s;
        s = '0;
        s.mode = M_IDLE;
        if (!(c inside {" ", 8'h09, 8'h0D, 8'h0A})) begin
            s.mark = 1'b1;
            if (c == "\"") begin
                s.mode = M_STR;
            end else if (is_alpha(c) || is_digit(c) || c == "$" || c == "@") begin
                s.emit = 1'b1;
                s.byte_val = c;
                if (is_alpha(c)) begin
                    s.mode = M_IDENT;
                    s.ttype = T_IDENT;
                end else if (is_digit(c)) begin
                    s.mode = M_INT;
                    s.ttype = T_INT;
                end else if (c == "$") begin
                    s.mode = M_VAR;
                    s.ttype = T_VAR;
                end else begin
                    s.mode = M_MAP;
                    s.ttype = T_MAP;
                end
            end else if (c inside {"=", "!", "+", "-", "&", "|", "<", ">", "/"}) begin
                s.mode = M_OP;
            end else if (c == "#") begin
                s.mode = M_LINE;
            end else begin
                s.emit = 1'b1;
                s.kind = 1'b1;
                s.ttype = T_OP;
                case (c)
                    "%": s.op = OP_MOD;
                    "*": s.op = OP_MUL;
                    "~": s.op = OP_BNOT;
                    "^": s.op = OP_XOR;
                    default: begin
                        s.op = OP_NONE;
                        if (punct_type(c) != T_INT) begin
                            s.ttype = punct_type(c);
                        end else begin
                            s.ttype = T_UNKNOWN;
                            s.byte_val = c;
                        end
                    end
                endcase
            end
        end
        return s;
    endfunction

endpackage

>>> rtl/core/script_lexer_stream.sv
// Script lexer top level: character-serial tokenizer with position tracking; uses sls_pkg.
// The results of a word are registered and appear in the cycle after it is accepted.
// Throughput: one word per cycle while each yields at most one result and the output is not stalled; a word
// with more than one result keeps the input stalled while the 3-entry result register drains.
// Reset (synchronous, active low) returns the lexer to idle at line 1, column 1.
module script_lexer_stream #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_item_kind,
    output logic [4:0]  o_token_type,
    output logic [4:0]  o_operator_code,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic        o_last
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [4:0]               r_mode, n_mode;
    logic [7:0]               r_pend, n_pend;
    logic [7:0]               r_esc, n_esc;
    logic [1:0]               r_digits, n_digits;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_sline, n_sline;
    logic [POSITION_BITS-1:0] r_scol, n_scol;
    sls_pkg::t_res            r_res [3];
    sls_pkg::t_res            n_res [3];
    logic [1:0]               r_cnt, n_cnt;
    logic [1:0]               r_idx;
    logic                     in_acc;
    logic                     out_acc;
    logic                     buf_free;

    function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic sls_pkg::t_res mk(input logic k, input logic [4:0] t,
                                         input logic [4:0] o, input logic [7:0] b,
                                         input logic [15:0] l, input logic [15:0] cl);
        sls_pkg::t_res r;
        r.kind = k;
        r.ttype = t;
        r.op = o;
        r.byte_val = b;
        r.line = l;
        r.col = cl;
        r.last = 1'b0;
        return r;
    endfunction

    assign o_out_valid = (r_idx < r_cnt);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign buf_free    = !o_out_valid || (out_acc && (r_idx + 2'd1 == r_cnt));
    assign o_in_stall  = !buf_free;
    assign in_acc      = i_in_valid && buf_free;

    assign o_item_kind     = r_res[r_idx].kind;
    assign o_token_type    = r_res[r_idx].ttype;
    assign o_operator_code = r_res[r_idx].op;
    assign o_byte_value    = r_res[r_idx].byte_val;
    assign o_token_line    = r_res[r_idx].line;
    assign o_token_column  = r_res[r_idx].col;
    assign o_last          = r_res[r_idx].last;

    always_comb begin
        logic [7:0]     c;
        logic [4:0]     h;
        logic [4:0]     op;
        logic           str_char;
        logic           do_start;
        sls_pkg::t_start s;

        c = i_char_code;
        h = sls_pkg::hex_val(c);
        op = sls_pkg::OP_NONE;
        str_char = 1'b0;
        do_start = 1'b0;
        s = '0;
        n_mode = r_mode;
        n_pend = r_pend;
        n_esc = r_esc;
        n_digits = r_digits;
        n_line = r_line;
        n_col = r_col;
        n_sline = r_sline;
        n_scol = r_scol;
        n_cnt = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_res[i] = '0;
        end

        if (i_end_of_input) begin
            case (r_mode)
                sls_pkg::M_IDENT, sls_pkg::M_VAR, sls_pkg::M_MAP, sls_pkg::M_INT: begin
                    n_res[n_cnt] = mk(1'b1, sls_pkg::mode_type(r_mode), sls_pkg::OP_NONE,
                                      8'd0, pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                end
                sls_pkg::M_OP: begin
                    n_res[n_cnt] = mk(1'b1, sls_pkg::T_OP, sls_pkg::single_op(r_pend),
                                      8'd0, pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                end
                sls_pkg::M_STR, sls_pkg::M_ESC: begin
                    n_res[n_cnt] = mk(1'b1, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                      8'd0, pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                end
                sls_pkg::M_HEX, sls_pkg::M_OCT: begin
                    n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                      r_esc, pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                    n_res[n_cnt] = mk(1'b1, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                      8'd0, pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_res[n_cnt] = mk(1'b1, sls_pkg::T_END, sls_pkg::OP_NONE, 8'd0,
                              pos16(r_line), pos16(r_col));
            n_cnt = n_cnt + 2'd1;
            n_mode = sls_pkg::M_IDLE;
            n_pend = 8'd0;
            n_esc = 8'd0;
            n_digits = 2'd0;
            n_line = POS_ONE;
            n_col = POS_ONE;
            n_sline = POS_ONE;
            n_scol = POS_ONE;
        end else begin
            case (r_mode)
                sls_pkg::M_IDENT, sls_pkg::M_VAR, sls_pkg::M_MAP, sls_pkg::M_INT: begin
                    if (sls_pkg::is_digit(c) ||
                        (r_mode != sls_pkg::M_INT && sls_pkg::is_alpha(c))) begin
                        n_res[n_cnt] = mk(1'b0, sls_pkg::mode_type(r_mode), sls_pkg::OP_NONE,
                                          c, pos16(r_sline), pos16(r_scol));
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        n_res[n_cnt] = mk(1'b1, sls_pkg::mode_type(r_mode), sls_pkg::OP_NONE,
                                          8'd0, pos16(r_sline), pos16(r_scol));
                        n_cnt = n_cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                sls_pkg::M_STR: begin
                    str_char = 1'b1;
                end
                sls_pkg::M_ESC: begin
                    n_mode = sls_pkg::M_STR;
                    case (c)
                        "a", "b", "t", "n", "v", "f", "r", "e", "\"", "'", "?", "\\": begin
                            case (c)
                                "a":     op = 5'd7;
                                "b":     op = 5'd8;
                                "t":     op = 5'd9;
                                "n":     op = 5'd10;
                                "v":     op = 5'd11;
                                "f":     op = 5'd12;
                                "r":     op = 5'd13;
                                "e":     op = 5'd27;
                                default: op = 5'd0;
                            endcase
                            n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                              (op == 5'd0) ? c : {3'b000, op},
                                              pos16(r_sline), pos16(r_scol));
                            n_cnt = n_cnt + 2'd1;
                            op = sls_pkg::OP_NONE;
                        end
                        8'h0A: begin
                        end
                        "x": begin
                            n_mode = sls_pkg::M_HEX;
                            n_esc = 8'd0;
                            n_digits = 2'd0;
                        end
                        default: begin
                            if (c inside {["0":"7"]}) begin
                                n_mode = sls_pkg::M_OCT;
                                n_esc = {5'd0, c[2:0]};
                                n_digits = 2'd1;
                            end else begin
                                n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                                  "\\", pos16(r_sline), pos16(r_scol));
                                n_cnt = n_cnt + 2'd1;
                                n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                                  c, pos16(r_sline), pos16(r_scol));
                                n_cnt = n_cnt + 2'd1;
                            end
                        end
                    endcase
                end
                sls_pkg::M_HEX: begin
                    if (h[4] && r_digits < 2'd2) begin
                        n_esc = {r_esc[3:0], h[3:0]};
                        n_digits = r_digits + 2'd1;
                        if (r_digits == 2'd1) begin
                            n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                              n_esc, pos16(r_sline), pos16(r_scol));
                            n_cnt = n_cnt + 2'd1;
                            n_mode = sls_pkg::M_STR;
                        end
                    end else begin
                        n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                          r_esc, pos16(r_sline), pos16(r_scol));
                        n_cnt = n_cnt + 2'd1;
                        n_mode = sls_pkg::M_STR;
                        str_char = 1'b1;
                    end
                end
                sls_pkg::M_OCT: begin
                    if ((c inside {["0":"7"]}) && r_digits < 2'd3) begin
                        n_esc = {r_esc[4:0], 3'b000} + {5'd0, c[2:0]};
                        n_digits = r_digits + 2'd1;
                        if (r_digits == 2'd2) begin
                            n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                              n_esc, pos16(r_sline), pos16(r_scol));
                            n_cnt = n_cnt + 2'd1;
                            n_mode = sls_pkg::M_STR;
                        end
                    end else begin
                        n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE,
                                          r_esc, pos16(r_sline), pos16(r_scol));
                        n_cnt = n_cnt + 2'd1;
                        n_mode = sls_pkg::M_STR;
                        str_char = 1'b1;
                    end
                end
                sls_pkg::M_OP: begin
                    n_mode = sls_pkg::M_IDLE;
                    if (r_pend == "/" && c == "/") begin
                        n_mode = sls_pkg::M_LINE;
                    end else if (r_pend == "/" && c == "*") begin
                        n_mode = sls_pkg::M_BLOCK;
                    end else begin
                        if (c == "=" && r_pend == "=") op = sls_pkg::OP_EQ;
                        else if (c == "=" && r_pend == "!") op = sls_pkg::OP_NE;
                        else if (c == "=" && r_pend == "<") op = sls_pkg::OP_LE;
                        else if (c == "=" && r_pend == ">") op = sls_pkg::OP_GE;
                        else if (c == r_pend && r_pend == "+") op = sls_pkg::OP_INC;
                        else if (c == r_pend && r_pend == "-") op = sls_pkg::OP_DEC;
                        else if (c == r_pend && r_pend == "&") op = sls_pkg::OP_LAND;
                        else if (c == r_pend && r_pend == "|") op = sls_pkg::OP_LOR;
                        else if (c == r_pend && r_pend == "<") op = sls_pkg::OP_SHL;
                        else if (c == r_pend && r_pend == ">") op = sls_pkg::OP_SHR;
                        if (op != sls_pkg::OP_NONE) begin
                            n_res[n_cnt] = mk(1'b1, sls_pkg::T_OP, op, 8'd0,
                                              pos16(r_sline), pos16(r_scol));
                            n_cnt = n_cnt + 2'd1;
                        end else begin
                            n_res[n_cnt] = mk(1'b1, sls_pkg::T_OP, sls_pkg::single_op(r_pend),
                                              8'd0, pos16(r_sline), pos16(r_scol));
                            n_cnt = n_cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                end
                sls_pkg::M_LINE: begin
                    if (c == 8'h0A) n_mode = sls_pkg::M_IDLE;
                end
                sls_pkg::M_BLOCK: begin
                    if (c == "*") n_mode = sls_pkg::M_STAR;
                end
                sls_pkg::M_STAR: begin
                    if (c == "/") n_mode = sls_pkg::M_IDLE;
                    else if (c != "*") n_mode = sls_pkg::M_BLOCK;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (str_char) begin
                if (c == "\"") begin
                    n_res[n_cnt] = mk(1'b1, sls_pkg::T_STR, sls_pkg::OP_NONE, 8'd0,
                                      pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                    n_mode = sls_pkg::M_IDLE;
                end else if (c == "\\") begin
                    n_mode = sls_pkg::M_ESC;
                end else begin
                    n_res[n_cnt] = mk(1'b0, sls_pkg::T_STR, sls_pkg::OP_NONE, c,
                                      pos16(r_sline), pos16(r_scol));
                    n_cnt = n_cnt + 2'd1;
                end
            end

            if (do_start) begin
                s = sls_pkg::start_token(c);
                n_mode = s.mode;
                if (s.mode == sls_pkg::M_OP) n_pend = c;
                if (s.mark) begin
                    n_sline = r_line;
                    n_scol = r_col;
                end
                if (s.emit) begin
                    n_res[n_cnt] = mk(s.kind, s.ttype, s.op, s.byte_val,
                                      pos16(n_sline), pos16(n_scol));
                    n_cnt = n_cnt + 2'd1;
                end
            end

            if (c == 8'h0A) begin
                if (r_line != POS_MAX) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end

        for (int i = 0; i < 3; i++) begin
            n_res[i].last = (n_cnt == 2'(i + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sls_pkg::M_IDLE;
            r_pend   <= 8'd0;
            r_esc    <= 8'd0;
            r_digits <= 2'd0;
            r_line   <= POS_ONE;
            r_col    <= POS_ONE;
            r_sline  <= POS_ONE;
            r_scol   <= POS_ONE;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else if (in_acc) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_esc    <= n_esc;
            r_digits <= n_digits;
            r_line   <= n_line;
            r_col    <= n_col;
            r_sline  <= n_sline;
            r_scol   <= n_scol;
            r_cnt    <= n_cnt;
            r_idx    <= 2'd0;
        end else if (out_acc) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt) else $error("result index beyond count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!o_out_valid || (out_acc && o_last)))
        else $error("input taken while results pending");
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_input) |=> (r_mode == sls_pkg::M_IDLE && r_line == POS_ONE))
        else $error("end of input did not reset lexer");
`endif

endmodule
